// File: sv/cca_pkg.sv
`default_nettype none
package cca_pkg;

   typedef enum logic [1:0] {
      ACT_ALLOC = 2'd0,
      ACT_FREE  = 2'd1,
      ACT_PACK  = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_BADSIZE = 2'd1,
      ST_NOHOLE  = 2'd2
   } status_type;

   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_BEST  = 2'd1;

   // One cell's contents, the unit that moves along the chain.
   typedef struct packed {
      logic       used;
      logic [7:0] owner;
   } slot_type;

   // Command broadcast from the sequencer to every cell.
   typedef struct packed {
      logic       rotate;   // shift the whole row one place toward cell zero
      logic       claim;    // claim flag; never set, and cca_cell does not act on it
      logic       clear;    // clear every cell whose owner matches
      logic       drop;     // packing round: a free cell trades with the owned one above
      logic [7:0] owner;
   } cell_cmd_type;

endpackage
`default_nettype wire

// File: sv/cca_cell.sv
`default_nettype none
module cca_cell
   import cca_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_cmd_type cmd,
   input  wire slot_type     from_next,
   input  wire slot_type     from_prev,
   input  wire logic         pair_low,
   input  wire logic         pair_high,
   output slot_type          slot
);

   slot_type slot_ff, slot_in;

   always_comb begin
      slot_in = slot_ff;
      if (cmd.clear) begin
         if (slot_ff.used && slot_ff.owner == cmd.owner) begin
            slot_in = '0;
         end
      end else if (cmd.rotate) begin
         slot_in = from_next;
      end else if (cmd.drop) begin
         // A free cell below an owned one swaps with it; free cells hold zero.
         if (pair_low && !slot_ff.used && from_next.used) begin
            slot_in = from_next;
         end else if (pair_high && slot_ff.used && !from_prev.used) begin
            slot_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot = slot_ff;

endmodule
`default_nettype wire

// File: sv/contiguous_cell_allocator.sv
// Channel  | Direction | Ports                                                    | Beat
// req      | in        | req_valid/ready, action, owner_id, request_size,        | one command
//          |           | fit_policy, cell_address                                 |
// rsp      | out       | rsp_valid/ready, status, start_address, cell_owner,     | one result
//          |           | cell_used                                                |
//
// The pool is a ring of POOL_CELLS cells; search, claim and read rotate it one
// place per cycle toward cell zero and the sequencer only looks at the head cell.
// Allocate takes two full rotations (search, then claim), or only the search
// when no hole is found. Compact runs POOL_CELLS rounds of neighbor swaps; a
// read takes one full rotation. Free and a rejected size go straight to the result.
// Reset clears every cell. A stalled result holds the block; the next request
// is taken only after the result beat is accepted.
`default_nettype none
module contiguous_cell_allocator
   import cca_pkg::*;
#(
   parameter int POOL_CELLS = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_action,
   input  wire logic [7:0] req_owner_id,
   input  wire logic [6:0] req_request_size,
   input  wire logic [1:0] req_fit_policy,
   input  wire logic [5:0] req_cell_address,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_status,
   output logic [5:0]      rsp_start_address,
   output logic [7:0]      rsp_cell_owner,
   output logic            rsp_cell_used
);

   localparam int CW = $clog2(POOL_CELLS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_SEARCH, S_CLAIM, S_PACK, S_READ, S_RESP
   } state_type;

   state_type    state_ff;
   slot_type     slots [POOL_CELLS];
   slot_type     tail_in;
   cell_cmd_type cmd;

   logic [CW-1:0] pos_ff;        // cells rotated so far
   logic [CW-1:0] cnt_ff;        // claim count
   logic [CW-1:0] run_start_ff, run_len_ff, best_start_ff, best_len_ff;
   logic          found_ff;
   logic [1:0]    act_ff, pol_ff;
   logic [7:0]    own_ff;
   logic [CW-1:0] size_ff;
   logic [5:0]    addr_ff;
   logic [1:0]    st_ff;
   logic [5:0]    start_ff;
   logic [7:0]    rown_ff;
   logic          rused_ff;

   // While packing, even and odd neighbor pairs take turns on alternate cycles;
   // POOL_CELLS rounds of this odd-even exchange move every owned cell down past
   // the free ones without changing the order of the owned cells.
   genvar g;
   generate
      for (g = 0; g < POOL_CELLS; g++) begin : g_cell
         localparam logic PAR = 1'(g % 2);
         slot_type nxt, prv;
         logic     lo, hi;
         if (g == POOL_CELLS - 1) begin : g_tail
            assign nxt = tail_in;
         end else begin : g_mid
            assign nxt = slots[g+1];
         end
         if (g == 0) begin : g_head
            assign prv = '0;
         end else begin : g_body
            assign prv = slots[g-1];
         end
         assign lo = (g < POOL_CELLS - 1) && (pos_ff[0] == PAR);
         assign hi = (g > 0) && (pos_ff[0] != PAR);
         cca_cell u_cell (.clock(clock), .reset(reset), .cmd(cmd),
                          .from_next(nxt), .from_prev(prv),
                          .pair_low(lo), .pair_high(hi), .slot(slots[g]));
      end
   endgenerate

   slot_type head;
   assign head = slots[0];

   // Run bookkeeping for the head cell during search.
   logic [CW-1:0] len_now, st_now;
   logic          run_end, qual, better;
   always_comb begin
      len_now = head.used ? run_len_ff : run_len_ff + CW'(1);
      st_now  = (run_len_ff == '0) ? pos_ff : run_start_ff;
      run_end = head.used || (pos_ff == CW'(POOL_CELLS - 1));
      qual    = (len_now >= size_ff) && (len_now != '0);
      if (!found_ff)               better = 1'b1;
      else if (pol_ff == POL_FIRST) better = 1'b0;
      else if (pol_ff == POL_BEST)  better = len_now < best_len_ff;
      else                          better = len_now > best_len_ff;
   end

   logic last;
   assign last = (pos_ff == CW'(POOL_CELLS - 1));

   always_comb begin
      cmd       = '0;
      cmd.owner = own_ff;
      tail_in   = head;
      case (state_ff)
         S_SEARCH, S_READ: cmd.rotate = 1'b1;
         S_CLAIM: begin
            cmd.rotate = 1'b1;
            if (pos_ff >= best_start_ff && cnt_ff < size_ff) begin
               tail_in.used  = 1'b1;
               tail_in.owner = own_ff;
            end
         end
         S_PACK: cmd.drop = 1'b1;
         S_IDLE: begin
            if (req_valid && action_type'(req_action) == ACT_FREE) begin
               cmd.clear = 1'b1;
               cmd.owner = req_owner_id;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pos_ff <= '0; cnt_ff <= '0; found_ff <= 1'b0;
         run_start_ff <= '0; run_len_ff <= '0;
         best_start_ff <= '0; best_len_ff <= '0;
         st_ff <= '0; start_ff <= '0; rown_ff <= '0; rused_ff <= 1'b0;
         act_ff <= '0; pol_ff <= '0; own_ff <= '0; size_ff <= '0; addr_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: if (req_valid) begin
               act_ff <= req_action; pol_ff <= req_fit_policy;
               own_ff <= req_owner_id; addr_ff <= req_cell_address;
               size_ff <= CW'(req_request_size);
               pos_ff <= '0; cnt_ff <= '0; found_ff <= 1'b0;
               run_len_ff <= '0; run_start_ff <= '0;
               st_ff <= ST_DONE; start_ff <= '0; rown_ff <= '0; rused_ff <= 1'b0;
               case (action_type'(req_action))
                  ACT_ALLOC: begin
                     if (req_request_size == '0 ||
                         32'(req_request_size) > POOL_CELLS) begin
                        st_ff <= ST_BADSIZE; state_ff <= S_RESP;
                     end else state_ff <= S_SEARCH;
                  end
                  ACT_FREE: state_ff <= S_RESP;
                  ACT_PACK: state_ff <= S_PACK;
                  default: begin
                     if (32'(req_cell_address) >= POOL_CELLS) state_ff <= S_RESP;
                     else state_ff <= S_READ;
                  end
               endcase
            end
            S_SEARCH: begin
               run_len_ff   <= head.used ? '0 : len_now;
               run_start_ff <= st_now;
               if (run_end && qual && better) begin
                  found_ff <= 1'b1; best_start_ff <= st_now; best_len_ff <= len_now;
               end
               pos_ff <= pos_ff + CW'(1);
               if (last) begin
                  pos_ff <= '0;
                  if (found_ff || (qual && better)) state_ff <= S_CLAIM;
                  else begin st_ff <= ST_NOHOLE; state_ff <= S_RESP; end
               end
            end
            S_CLAIM: begin
               if (pos_ff >= best_start_ff && cnt_ff < size_ff) cnt_ff <= cnt_ff + CW'(1);
               pos_ff <= pos_ff + CW'(1);
               if (last) begin
                  start_ff <= 6'(best_start_ff); state_ff <= S_RESP;
               end
            end
            S_PACK: begin
               pos_ff <= pos_ff + CW'(1);
               if (last) begin pos_ff <= '0; state_ff <= S_RESP; end
            end
            S_READ: begin
               if (pos_ff == CW'(addr_ff)) begin
                  rused_ff <= head.used; rown_ff <= head.used ? head.owner : '0;
               end
               pos_ff <= pos_ff + CW'(1);
               if (last) state_ff <= S_RESP;
            end
            S_RESP: if (rsp_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = (state_ff == S_RESP);
   assign rsp_status        = st_ff;
   assign rsp_start_address = start_ff;
   assign rsp_cell_owner    = rown_ff;
   assign rsp_cell_used     = rused_ff;

endmodule
`default_nettype wire

// File: tb/contiguous_cell_allocator_checker.sv
`default_nettype none
module contiguous_cell_allocator_checker
   import cca_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [1:0] req_action,
   input  wire logic [7:0] req_owner_id,
   input  wire logic [6:0] req_request_size,
   input  wire logic [1:0] req_fit_policy,
   input  wire logic [5:0] req_cell_address,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [1:0] rsp_status,
   input  wire logic [5:0] rsp_start_address,
   input  wire logic [7:0] rsp_cell_owner,
   input  wire logic       rsp_cell_used,
   output int              fail_count,
   output int              pending_count,
   output int              result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CELLS = 64;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] start;
      logic [7:0] owner;
      logic       used;
   } outcome_type;

   logic [7:0]  pool_owner [CELLS];
   logic        pool_used [CELLS];
   outcome_type outcome_queue [$];

   // Claims a hole by policy; returns the status code.
   function automatic logic [1:0] claim_hole(input logic [7:0] owner, input int size,
                                             input logic [1:0] policy,
                                             output logic [5:0] start);
      bit found;
      int best_start, best_len, i, j;
      found = 0;
      best_start = 0;
      best_len = 0;
      i = 0;
      start = '0;
      while (i < CELLS) begin
         if (pool_used[i]) begin
            i++;
            continue;
         end
         j = i;
         while (j < CELLS && !pool_used[j]) j++;
         if (j - i >= size) begin
            if (!found || (policy == POL_BEST && j - i < best_len) ||
                (policy != POL_FIRST && policy != POL_BEST && j - i > best_len)) begin
               found = 1;
               best_start = i;
               best_len = j - i;
            end
         end
         if (found && policy == POL_FIRST) break;
         i = j;
      end
      if (!found) return ST_NOHOLE;
      for (int k = best_start; k < best_start + size && k < CELLS; k++) begin
         pool_used[k] = 1'b1;
         pool_owner[k] = owner;
      end
      start = best_start[5:0];
      return ST_DONE;
   endfunction

   function automatic outcome_type apply_command(input logic [1:0] action,
                                                 input logic [7:0] owner,
                                                 input logic [6:0] size,
                                                 input logic [1:0] policy,
                                                 input logic [5:0] addr);
      outcome_type o;
      int w;
      o = '0;
      case (action)
         ACT_ALLOC: begin
            if (size == 0 || size > CELLS) o.status = ST_BADSIZE;
            else o.status = claim_hole(owner, int'(size), policy, o.start);
         end
         ACT_FREE: begin
            for (int k = 0; k < CELLS; k++)
               if (pool_used[k] && pool_owner[k] == owner) begin
                  pool_used[k] = 1'b0;
                  pool_owner[k] = '0;
               end
         end
         ACT_PACK: begin
            w = 0;
            for (int k = 0; k < CELLS; k++)
               if (pool_used[k]) begin
                  o.owner = pool_owner[k];
                  pool_used[k] = 1'b0;
                  pool_owner[k] = '0;
                  pool_used[w] = 1'b1;
                  pool_owner[w] = o.owner;
                  w++;
               end
            o.owner = '0;
         end
         default: begin
            if (pool_used[addr]) begin
               o.used = 1'b1;
               o.owner = pool_owner[addr];
            end
         end
      endcase
      return o;
   endfunction

   outcome_type got, want;

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CELLS; k++) begin
            pool_owner[k] = '0;
            pool_used[k] = 1'b0;
         end
         outcome_queue.delete();
         fail_count <= 0;
         result_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_start_address, rsp_cell_owner, rsp_cell_used};
            result_count <= result_count + 1;
            if (outcome_queue.size() == 0) begin
               $display("%0t: unexpected result beat %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = outcome_queue.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch status exp %0d got %0d start exp %0d got %0d",
                           $time, want.status, got.status, want.start, got.start);
                  $display("%0t:   owner exp %0d got %0d used exp %0d got %0d",
                           $time, want.owner, got.owner, want.used, got.used);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready)
            outcome_queue.push_back(apply_command(req_action, req_owner_id,
                                                  req_request_size, req_fit_policy,
                                                  req_cell_address));
      end
      pending_count <= outcome_queue.size();
   end
endmodule
`default_nettype wire

// File: tb/contiguous_cell_allocator_tb.sv
`default_nettype none
module contiguous_cell_allocator_tb;
   import cca_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BEATS = 1430;
   localparam int STALL_LIMIT  = 4000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_action = '0;
   logic [7:0] req_owner_id = '0;
   logic [6:0] req_request_size = '0;
   logic [1:0] req_fit_policy = '0;
   logic [5:0] req_cell_address = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [5:0] rsp_start_address;
   logic [7:0] rsp_cell_owner;
   logic       rsp_cell_used;
   int         fail_count, pending_count, result_count;

   // Idle percentages for each side; the stimulus process walks them through the phases.
   int  send_idle_pct = 14;
   int  recv_idle_pct = 59;
   bit  hold_receiver = 1'b0;
   int  quiet_cycles = 0;
   int  sent_beats = 0;

   always #10 clock = ~clock;

   contiguous_cell_allocator DUT (.*);

   contiguous_cell_allocator_checker u_checker (.*);

   // The receiver stalls at random; during a forced hold it stays low so the
   // block backs up and stops taking requests.
   always @(posedge clock) begin
      if (reset || hold_receiver) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // The watchdog counts cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("Watchdog expired at %0t", $time);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Offers one beat, holds it until accepted, then idles at random.
   task automatic send_beat(input logic [1:0] action, input logic [7:0] owner,
                            input logic [6:0] size, input logic [1:0] policy,
                            input logic [5:0] addr);
      req_valid <= 1'b1;
      req_action <= action;
      req_owner_id <= owner;
      req_request_size <= size;
      req_fit_policy <= policy;
      req_cell_address <= addr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_beats++;
      // Lower valid only when the next beat does not follow at once.
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Random beat: mostly allocations and reads so that the pool fills and
   // fragments, with frees of a few recurring owners to punch holes in it.
   task automatic send_random();
      logic [1:0] action;
      logic [6:0] size;
      int pick;
      pick = $urandom_range(99);
      if (pick < 45) action = ACT_ALLOC;
      else if (pick < 65) action = ACT_FREE;
      else if (pick < 72) action = ACT_PACK;
      else action = ACT_READ;
      pick = $urandom_range(99);
      if (pick < 75) size = 7'($urandom_range(1, 12));
      else if (pick < 85) size = 7'($urandom_range(13, 64));
      else size = 7'($urandom);
      send_beat(action,
                ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 8)),
                size, 2'($urandom), 6'($urandom));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: size extremes, every policy, no hole, undefined policy,
      // reads of free and owned cells, frees and compaction.
      send_beat(ACT_READ, 8'hFF, 7'd0, 2'd0, 6'd0);
      send_beat(ACT_ALLOC, 8'h01, 7'd0, POL_FIRST, 6'd0);
      send_beat(ACT_ALLOC, 8'h01, 7'd65, POL_FIRST, 6'd0);
      send_beat(ACT_ALLOC, 8'h01, 7'd127, POL_FIRST, 6'd0);
      send_beat(ACT_ALLOC, 8'hFF, 7'd64, POL_FIRST, 6'd0);
      send_beat(ACT_READ, 8'h00, 7'd0, 2'd0, 6'd63);
      send_beat(ACT_ALLOC, 8'h02, 7'd1, POL_FIRST, 6'd0);
      send_beat(ACT_FREE, 8'hFF, 7'd0, 2'd0, 6'd0);
      send_beat(ACT_ALLOC, 8'h01, 7'd5, POL_FIRST, 6'd0);
      send_beat(ACT_ALLOC, 8'h02, 7'd10, POL_FIRST, 6'd0);
      send_beat(ACT_ALLOC, 8'h03, 7'd3, POL_FIRST, 6'd0);
      send_beat(ACT_ALLOC, 8'h04, 7'd20, POL_FIRST, 6'd0);
      send_beat(ACT_FREE, 8'h01, 7'd0, 2'd0, 6'd0);
      send_beat(ACT_FREE, 8'h03, 7'd0, 2'd0, 6'd0);
      send_beat(ACT_ALLOC, 8'h05, 7'd2, POL_BEST, 6'd0);
      send_beat(ACT_ALLOC, 8'h06, 7'd2, 2'd2, 6'd0);
      send_beat(ACT_ALLOC, 8'h07, 7'd2, 2'd3, 6'd0);
      send_beat(ACT_ALLOC, 8'h08, 7'd60, POL_FIRST, 6'd0);
      send_beat(ACT_READ, 8'h00, 7'd0, 2'd0, 6'd15);
      send_beat(ACT_PACK, 8'h00, 7'd0, 2'd0, 6'd0);
      send_beat(ACT_READ, 8'h00, 7'd0, 2'd0, 6'd0);
      send_beat(ACT_READ, 8'h00, 7'd0, 2'd0, 6'd40);
      send_beat(ACT_ALLOC, 8'h09, 7'd64, POL_BEST, 6'd0);

      // The sender pauses until every result is back.
      drain();

      // Long receiver hold while the sender keeps offering beats.
      fork
         begin
            hold_receiver = 1'b1;
            repeat (600) @(posedge clock);
            hold_receiver = 1'b0;
         end
         repeat (8) send_random();
      join

      for (int k = 0; k < RANDOM_BEATS; k++) begin
         if (k == RANDOM_BEATS / 3) begin
            send_idle_pct = 59;
            recv_idle_pct = 14;
         end else if (k == 2 * RANDOM_BEATS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_random();
      end
      drain();
      repeat (300) @(posedge clock);

      $display("Ran %0d command beats and checked %0d result beats across all", sent_beats,
               result_count);
      $display("actions, fit policies, size extremes and back-pressure phases.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
